@@ rtl/core/enms_pkg.sv @@
package enms_pkg;

  // Field widths
  localparam int PIX_W = 8;
  localparam int DIR_W = 8;
  localparam int ROW_W = 16;
  localparam int COL_W = 10;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_WIDTH_W = 11;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_WIDTH_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0]       RST_IMAGE_HEIGHT = 16'd480;

  // Defaults for top-level parameters
  localparam int DEF_MAX_WIDTH   = 1024;
  localparam int DEF_QUEUE_DEPTH = 4;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_0   = 8'd0;
  localparam logic [DIR_W-1:0] DIR_45  = 8'd45;
  localparam logic [DIR_W-1:0] DIR_90  = 8'd90;
  localparam logic [DIR_W-1:0] DIR_135 = 8'd135;

  // Result kinds within one queue entry, in raster order
  localparam int RES_UP_PREV  = 0;  // row r-1, column c-1
  localparam int RES_UP_LAST  = 1;  // row r-1, last column
  localparam int RES_CUR_PREV = 2;  // last row, column c-1
  localparam int RES_CUR_LAST = 3;  // last row, last column (frame end)
  localparam int NUM_RES      = 4;

  typedef struct packed {
    logic [PIX_W-1:0] magnitude;
    logic [DIR_W-1:0] direction;
  } in_t;

  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             frame_last;
  } out_t;

  // One window column: rows r-2, r-1, r and the directions of rows r-1, r
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
    logic [DIR_W-1:0] dmid;
    logic [DIR_W-1:0] dbot;
  } col_t;

  // Work handed from front to back: left, centre-prev and current columns
  typedef struct packed {
    col_t               x0;
    col_t               x1;
    col_t               x2;
    logic [NUM_RES-1:0] mask;
    logic [ROW_W-1:0]   row_up;
    logic [ROW_W-1:0]   row_cur;
    logic [COL_W-1:0]   col_prev;
    logic [COL_W-1:0]   col_cur;
  } entry_t;

endpackage

@@ rtl/core/edge_non_maximum_suppression_top.sv @@
// Canny non-maximum suppression on a raster stream of magnitude/direction
// pixels, 3x3 window with mirrored borders. Accepts one pixel per clock and
// delivers one result per clock unless the queue fills or the output stalls;
// a result passes the read stage, the entry queue and the output register.
// On the last row of a frame most inputs complete two results, so there the
// output port sets the pace of the input. Line stores are single memories of
// MAX_WIDTH entries read once per pixel; the row-two-above store is written
// in the cycle after the read that feeds it. Writing a register restarts the
// frame at row 0, column 0. No clearing pass after reset.
module edge_non_maximum_suppression_top #(
  parameter int MAX_WIDTH   = enms_pkg::DEF_MAX_WIDTH,
  parameter int QUEUE_DEPTH = enms_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  enms_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output enms_pkg::out_t                out_data_o,
  input  logic                          cfg_we_i,
  input  logic [enms_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [enms_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import enms_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int CMP_W = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
  localparam int QCW   = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_WIDTH_W-1:0] width_q;
  logic [ROW_W-1:0]       height_q;
  logic [CMP_W-1:0]       width_ext, width_clamp;
  logic [WW-1:0]          width_eff;
  logic [ROW_W-1:0]       height_eff;
  logic                   restart;

  logic           push, pop, empty;
  entry_t         push_data, head;
  logic [QCW-1:0] q_count;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_IMAGE_WIDTH) begin
        width_q <= cfg_data_i[CFG_WIDTH_W-1:0];
      end else if (cfg_idx_i == CFG_IMAGE_HEIGHT) begin
        height_q <= cfg_data_i;
      end
    end
  end

  assign restart = cfg_we_i &&
                   (cfg_idx_i == CFG_IMAGE_WIDTH || cfg_idx_i == CFG_IMAGE_HEIGHT);

  // Clamp geometry to the supported range
  assign width_ext = CMP_W'(width_q);
  always_comb begin
    if (width_ext < CMP_W'(2))              width_clamp = CMP_W'(2);
    else if (width_ext > CMP_W'(MAX_WIDTH)) width_clamp = CMP_W'(MAX_WIDTH);
    else                                    width_clamp = width_ext;
  end
  assign width_eff  = WW'(width_clamp);
  assign height_eff = (height_q < ROW_W'(2)) ? ROW_W'(2) : height_q;

  enms_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .restart_i  (restart),
    .q_count_i  (q_count),
    .push_o     (push),
    .push_data_o(push_data)
  );

  enms_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (pop),
    .empty_o    (empty),
    .head_o     (head),
    .count_o    (q_count)
  );

  enms_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_i     (head),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

@@ rtl/core/enms_front.sv @@
module enms_front #(
  parameter int MAX_WIDTH   = enms_pkg::DEF_MAX_WIDTH,
  parameter int QUEUE_DEPTH = enms_pkg::DEF_QUEUE_DEPTH,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int QCW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  enms_pkg::in_t            in_data_i,
  input  logic [WW-1:0]            width_i,
  input  logic [enms_pkg::ROW_W-1:0] height_i,
  input  logic                     restart_i,
  input  logic [QCW-1:0]           q_count_i,
  output logic                     push_o,
  output enms_pkg::entry_t         push_data_o
);
  import enms_pkg::*;

  logic [ROW_W-1:0] row_q;
  logic [CW-1:0]    col_q;
  logic             accept, last_col, last_row;
  logic [NUM_RES-1:0] mask;

  // Line stores: row r-1 and row r-2 magnitudes, row r-1 directions
  logic [PIX_W-1:0] mid_mem [MAX_WIDTH];
  logic [PIX_W-1:0] top_mem [MAX_WIDTH];
  logic [DIR_W-1:0] dir_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_mid_q, rd_top_q;
  logic [DIR_W-1:0] rd_dir_q;

  // Stage after the read
  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_mag_q;
  logic [DIR_W-1:0] s1_dir_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_row1_q, s1_col1_q;
  logic [NUM_RES-1:0] s1_mask_q;
  logic [ROW_W-1:0] s1_row_up_q, s1_row_cur_q;
  logic [COL_W-1:0] s1_col_prev_q, s1_col_cur_q;

  col_t cur_col, win0_q, win1_q;

  // Credit check keeps room for the item in flight
  assign in_ready_o = ({1'b0, q_count_i} + (QCW+1)'(s1_valid_q)) < (QCW+1)'(QUEUE_DEPTH);
  assign accept     = in_valid_i && in_ready_o;

  assign last_col = (WW'(col_q) == width_i - WW'(1));
  assign last_row = (row_q == height_i - ROW_W'(1));

  // Which results this pixel completes
  always_comb begin
    mask = '0;
    if (row_q != '0) begin
      mask[RES_UP_PREV]  = (col_q != '0);
      mask[RES_UP_LAST]  = last_col;
      mask[RES_CUR_PREV] = last_row && (col_q != '0);
      mask[RES_CUR_LAST] = last_row && last_col;
    end
  end

  // Raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (restart_i) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Line stores: read-before-write, row r-2 store filled in the following cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_mid_q       <= mid_mem[col_q];
      rd_top_q       <= top_mem[col_q];
      rd_dir_q       <= dir_mem[col_q];
      mid_mem[col_q] <= in_data_i.magnitude;
      dir_mem[col_q] <= in_data_i.direction;
    end
    if (s1_valid_q) begin
      top_mem[s1_col_q] <= rd_mid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_mag_q      <= in_data_i.magnitude;
      s1_dir_q      <= in_data_i.direction;
      s1_col_q      <= col_q;
      s1_row1_q     <= (row_q == ROW_W'(1));
      s1_col1_q     <= (col_q == CW'(1));
      s1_mask_q     <= mask;
      s1_row_up_q   <= row_q - ROW_W'(1);
      s1_row_cur_q  <= row_q;
      s1_col_prev_q <= COL_W'(col_q - CW'(1));
      s1_col_cur_q  <= COL_W'(col_q);
    end
  end

  // Current column; on row 1 the row above mirrors to the incoming row
  always_comb begin
    cur_col.top  = s1_row1_q ? s1_mag_q : rd_top_q;
    cur_col.mid  = rd_mid_q;
    cur_col.bot  = s1_mag_q;
    cur_col.dmid = rd_dir_q;
    cur_col.dbot = s1_dir_q;
  end

  // Window columns c-1 and c-2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win0_q <= '0;
      win1_q <= '0;
    end else if (s1_valid_q) begin
      win0_q <= cur_col;
      win1_q <= win0_q;
    end
  end

  // Entry; column -1 mirrors to column 1
  assign push_o = s1_valid_q && (s1_mask_q != '0);
  always_comb begin
    push_data_o.x0       = s1_col1_q ? cur_col : win1_q;
    push_data_o.x1       = win0_q;
    push_data_o.x2       = cur_col;
    push_data_o.mask     = s1_mask_q;
    push_data_o.row_up   = s1_row_up_q;
    push_data_o.row_cur  = s1_row_cur_q;
    push_data_o.col_prev = s1_col_prev_q;
    push_data_o.col_cur  = s1_col_cur_q;
  end

endmodule

@@ rtl/core/enms_queue.sv @@
module enms_queue #(
  parameter int DEPTH = enms_pkg::DEF_QUEUE_DEPTH,
  localparam int PW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int QCW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  enms_pkg::entry_t push_data_i,
  input  logic             pop_i,
  output logic             empty_o,
  output enms_pkg::entry_t head_o,
  output logic [QCW-1:0]   count_o
);
  import enms_pkg::*;

  entry_t         mem_q [DEPTH];
  logic [PW-1:0]  wr_q, rd_q;
  logic [QCW-1:0] count_q;

  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      count_q <= count_q + QCW'(push_i) - QCW'(pop_i);
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i && !pop_i |-> count_q < QCW'(DEPTH))
    else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("queue underflow");
`endif

endmodule

@@ rtl/core/enms_back.sv @@
module enms_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  enms_pkg::entry_t head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output enms_pkg::out_t   out_data_o
);
  import enms_pkg::*;

  logic [NUM_RES-1:0] done_q, remaining, sel;
  logic [1:0]         idx;
  logic               fire, out_valid_q;
  col_t               cl, cc, cr;
  logic [PIX_W-1:0]   ul, uc, ur, ml, mc, mr, dl, dc, dr;
  logic [DIR_W-1:0]   dir;
  logic [PIX_W-1:0]   n1, n2, value;
  logic               known;
  out_t               out_q;

  // Next result of the head entry, in raster order
  assign remaining = head_i.mask & ~done_q;
  always_comb begin
    idx = 2'd0;
    if (remaining[RES_UP_PREV])       idx = 2'(RES_UP_PREV);
    else if (remaining[RES_UP_LAST])  idx = 2'(RES_UP_LAST);
    else if (remaining[RES_CUR_PREV]) idx = 2'(RES_CUR_PREV);
    else                              idx = 2'(RES_CUR_LAST);
    sel = NUM_RES'(1) << idx;
  end

  // Columns: last-column results mirror the right neighbour to the left
  always_comb begin
    cl = idx[0] ? head_i.x1 : head_i.x0;
    cc = idx[0] ? head_i.x2 : head_i.x1;
    cr = idx[0] ? head_i.x1 : head_i.x2;
  end

  // Rows: last-row results mirror the row below to the row above
  always_comb begin
    if (idx[1]) begin
      ul = cl.mid; uc = cc.mid; ur = cr.mid;
      ml = cl.bot; mc = cc.bot; mr = cr.bot;
      dl = cl.mid; dc = cc.mid; dr = cr.mid;
      dir = cc.dbot;
    end else begin
      ul = cl.top; uc = cc.top; ur = cr.top;
      ml = cl.mid; mc = cc.mid; mr = cr.mid;
      dl = cl.bot; dc = cc.bot; dr = cr.bot;
      dir = cc.dmid;
    end
  end

  // Neighbours along the gradient direction
  always_comb begin
    known = 1'b1;
    n1 = '0;
    n2 = '0;
    case (dir)
      DIR_0:   begin n1 = ml; n2 = mr; end
      DIR_45:  begin n1 = ur; n2 = dl; end
      DIR_90:  begin n1 = dc; n2 = uc; end
      DIR_135: begin n1 = dr; n2 = ul; end
      default: known = 1'b0;
    endcase
    value = (!known || (mc >= n1 && mc >= n2)) ? mc : '0;
  end

  assign fire  = !empty_i && (!out_valid_q || out_ready_i);
  assign pop_o = fire && ((remaining & ~sel) == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        done_q <= pop_o ? '0 : (done_q | sel);
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.value      <= value;
      out_q.row        <= idx[1] ? head_i.row_cur : head_i.row_up;
      out_q.column     <= idx[0] ? head_i.col_cur : head_i.col_prev;
      out_q.frame_last <= (idx == 2'(RES_CUR_LAST));
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_fire_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_i |-> remaining != '0)
    else $error("head entry has no result left");
  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> done_q == '0)
    else $error("progress mask not cleared on pop");
`endif

endmodule
